### src/i2cmts_pkg.sv
// i2cmts_pkg: shared types and codes for the i2c master transaction sequencer
// no dependencies; imported by the front, back and top-level modules
package i2cmts_pkg;

	// input transaction as seen on the item channel
	typedef struct packed {
		logic       opcode;
		logic [1:0] mode;
		logic [6:0] target_addr;
		logic [7:0] tx_count;
		logic [7:0] rx_count;
		logic [7:0] link_status;
		logic [7:0] rx_byte;
		logic [7:0] tx_byte;
	} item_t;

	// result transaction as seen on the result channel
	typedef struct packed {
		logic [2:0] action;
		logic [7:0] send_value;
		logic       tx_taken;
		logic       rx_valid;
		logic [7:0] rx_out;
		logic       done_res;
		logic       failed;
	} result_t;

	// classified command held in the queue between front and back
	typedef struct packed {
		logic       is_event;
		logic       req_ok;
		logic [1:0] kind;
		logic [6:0] target;
		logic [7:0] tx_cnt;
		logic [7:0] rx_cnt;
		logic [4:0] status;
		logic [7:0] rx_byte;
		logic [7:0] tx_byte;
	} cmd_t;

	// opcode values
	localparam logic OP_REQUEST = 1'b0;
	localparam logic OP_EVENT   = 1'b1;

	// request kinds
	localparam logic [1:0] KIND_WRITE   = 2'd0;
	localparam logic [1:0] KIND_READ    = 2'd1;
	localparam logic [1:0] KIND_WR_RD   = 2'd2;
	localparam logic [1:0] KIND_INVALID = 2'd3;

	// bus actions
	localparam logic [2:0] ACT_NONE    = 3'd0;
	localparam logic [2:0] ACT_START   = 3'd1;
	localparam logic [2:0] ACT_SEND    = 3'd2;
	localparam logic [2:0] ACT_RX_ACK  = 3'd3;
	localparam logic [2:0] ACT_RX_NACK = 3'd4;
	localparam logic [2:0] ACT_STOP    = 3'd5;

	// status codes, top five bits of the raw status byte
	localparam logic [4:0] ST_BUS_START = 5'h01; // 0x08
	localparam logic [4:0] ST_REP_START = 5'h02; // 0x10
	localparam logic [4:0] ST_SLA_W     = 5'h03; // 0x18
	localparam logic [4:0] ST_DATA_W    = 5'h05; // 0x28
	localparam logic [4:0] ST_SLA_R     = 5'h08; // 0x40
	localparam logic [4:0] ST_DATA_RA   = 5'h0A; // 0x50
	localparam logic [4:0] ST_DATA_RN   = 5'h0B; // 0x58

endpackage

### src/i2cmts_stream_if.sv
// i2cmts_stream_if: valid/ready channel carrying one transaction payload
// payload type given by parameter; no other dependencies
interface i2cmts_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### src/i2cmts_front.sv
// i2cmts_front: accepts item transactions, classifies them and queues commands
// depends on i2cmts_pkg and i2cmts_stream_if
module i2cmts_front #(
	parameter int unsigned MAX_BYTES   = 255,
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	i2cmts_stream_if.sink      items,
	output logic               head_valid,
	output i2cmts_pkg::cmd_t   head,
	input  logic               pop
);
	import i2cmts_pkg::*;

	localparam int unsigned CLIP   = (MAX_BYTES > 255) ? 255 : MAX_BYTES;
	localparam logic [7:0]  CLIP_B = CLIP[7:0];
	localparam int unsigned PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	cmd_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	cmd_t             cls;
	logic [7:0]       rx_clip;
	logic             push;

	// classify: mask status, clip counts, zero read count becomes one
	always_comb begin
		rx_clip      = (items.data.rx_count > CLIP_B) ? CLIP_B : items.data.rx_count;
		cls.is_event = (items.data.opcode == OP_EVENT);
		cls.req_ok   = (items.data.mode != KIND_INVALID);
		cls.kind     = items.data.mode;
		cls.target   = items.data.target_addr;
		cls.tx_cnt   = (items.data.tx_count > CLIP_B) ? CLIP_B : items.data.tx_count;
		cls.rx_cnt   = (rx_clip == 8'd0) ? 8'd1 : rx_clip;
		cls.status   = items.data.link_status[7:3];
		cls.rx_byte  = items.data.rx_byte;
		cls.tx_byte  = items.data.tx_byte;
	end

	assign items.ready = (count_q != FULL_CNT);
	assign push        = items.valid && items.ready;
	assign head_valid  = (count_q != '0);
	assign head        = mem_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

### src/i2cmts_back.sv
// i2cmts_back: transaction state machine that turns queued commands into bus actions
// depends on i2cmts_pkg and i2cmts_stream_if
module i2cmts_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  i2cmts_pkg::cmd_t   head,
	output logic               pop,
	i2cmts_stream_if.source    results
);
	import i2cmts_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_START,
		PH_SLA_W,
		PH_DATA_W,
		PH_RESTART,
		PH_SLA_R,
		PH_RX_ACK,
		PH_RX_NACK
	} phase_t;

	phase_t     phase_q;
	logic [6:0] target_q;
	logic [1:0] kind_q;
	logic [7:0] writes_q;
	logic [7:0] reads_q;
	logic       out_valid_q;
	result_t    res_q;

	phase_t     nxt_phase;
	logic [6:0] nxt_target;
	logic [1:0] nxt_kind;
	logic [7:0] nxt_writes;
	logic [7:0] nxt_reads;
	result_t    nxt_res;
	logic [4:0] expect_st;
	logic [7:0] reads_dec;

	assign pop           = head_valid && (!out_valid_q || results.ready);
	assign results.valid = out_valid_q;
	assign results.data  = res_q;
	assign reads_dec     = (reads_q != 8'd0) ? reads_q - 8'd1 : reads_q;

	// status expected in each phase
	always_comb begin
		case (phase_q)
			PH_START:   expect_st = ST_BUS_START;
			PH_SLA_W:   expect_st = ST_SLA_W;
			PH_DATA_W:  expect_st = ST_DATA_W;
			PH_RESTART: expect_st = ST_REP_START;
			PH_SLA_R:   expect_st = ST_SLA_R;
			PH_RX_ACK:  expect_st = ST_DATA_RA;
			PH_RX_NACK: expect_st = ST_DATA_RN;
			default:    expect_st = '0;
		endcase
	end

	// next action and state for the command at the queue head
	always_comb begin
		nxt_res    = '0;
		nxt_phase  = phase_q;
		nxt_target = target_q;
		nxt_kind   = kind_q;
		nxt_writes = writes_q;
		nxt_reads  = reads_q;
		if (!head.is_event) begin
			// new request, taken only when idle
			if (phase_q == PH_IDLE && head.req_ok) begin
				nxt_target     = head.target;
				nxt_kind       = head.kind;
				nxt_writes     = head.tx_cnt;
				nxt_reads      = head.rx_cnt;
				nxt_res.action = ACT_START;
				nxt_phase      = PH_START;
			end
		end else if (phase_q != PH_IDLE) begin
			if (head.status != expect_st) begin
				// unexpected status aborts the transaction
				nxt_res.action   = ACT_STOP;
				nxt_res.done_res = 1'b1;
				nxt_res.failed   = 1'b1;
				nxt_phase        = PH_IDLE;
			end else begin
				case (phase_q)
					PH_START: begin
						nxt_res.action = ACT_SEND;
						if (kind_q == KIND_READ) begin
							nxt_res.send_value = {target_q, 1'b1};
							nxt_phase          = PH_SLA_R;
						end else begin
							nxt_res.send_value = {target_q, 1'b0};
							nxt_phase          = PH_SLA_W;
						end
					end
					PH_SLA_W, PH_DATA_W: begin
						if (writes_q != 8'd0) begin
							nxt_res.action     = ACT_SEND;
							nxt_res.send_value = head.tx_byte;
							nxt_res.tx_taken   = 1'b1;
							nxt_writes         = writes_q - 8'd1;
							nxt_phase          = PH_DATA_W;
						end else if (kind_q == KIND_WR_RD) begin
							nxt_res.action = ACT_START;
							nxt_phase      = PH_RESTART;
						end else begin
							nxt_res.action   = ACT_STOP;
							nxt_res.done_res = 1'b1;
							nxt_phase        = PH_IDLE;
						end
					end
					PH_RESTART: begin
						nxt_res.action     = ACT_SEND;
						nxt_res.send_value = {target_q, 1'b1};
						nxt_phase          = PH_SLA_R;
					end
					PH_SLA_R: begin
						if (reads_q > 8'd1) begin
							nxt_res.action = ACT_RX_ACK;
							nxt_phase      = PH_RX_ACK;
						end else begin
							nxt_res.action = ACT_RX_NACK;
							nxt_phase      = PH_RX_NACK;
						end
					end
					PH_RX_ACK: begin
						nxt_res.rx_valid = 1'b1;
						nxt_res.rx_out   = head.rx_byte;
						nxt_reads        = reads_dec;
						if (reads_dec > 8'd1) begin
							nxt_res.action = ACT_RX_ACK;
							nxt_phase      = PH_RX_ACK;
						end else begin
							nxt_res.action = ACT_RX_NACK;
							nxt_phase      = PH_RX_NACK;
						end
					end
					default: begin
						// last byte received with nack
						nxt_res.rx_valid = 1'b1;
						nxt_res.rx_out   = head.rx_byte;
						nxt_res.action   = ACT_STOP;
						nxt_res.done_res = 1'b1;
						nxt_reads        = 8'd0;
						nxt_phase        = PH_IDLE;
					end
				endcase
			end
		end
	end

	// state and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			target_q    <= '0;
			kind_q      <= '0;
			writes_q    <= '0;
			reads_q     <= '0;
			out_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (pop) begin
				phase_q     <= nxt_phase;
				target_q    <= nxt_target;
				kind_q      <= nxt_kind;
				writes_q    <= nxt_writes;
				reads_q     <= nxt_reads;
				res_q       <= nxt_res;
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// a failure always ends the transaction with a stop
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.failed |-> res_q.done_res && res_q.action == ACT_STOP)
		else $error("failed result without stop and done");

	// a consumed write byte is always the byte being sent
	assert property (@(posedge clk) disable iff (!arst_n)
		pop && nxt_res.tx_taken |=> res_q.action == ACT_SEND &&
			res_q.send_value == $past(head.tx_byte))
		else $error("tx byte taken without being sent");

	// a delivered read byte only comes with a receive or the closing stop
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.rx_valid |-> res_q.action == ACT_RX_ACK ||
			res_q.action == ACT_RX_NACK || res_q.action == ACT_STOP)
		else $error("rx byte delivered with wrong action");

	// the sequencer is idle after every finished transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		pop && nxt_res.done_res |=> phase_q == PH_IDLE)
		else $error("transaction done but phase not idle");
endmodule

### src/i2c_master_transaction_sequencer.sv
// i2c_master_transaction_sequencer: top level, front classifier and queue plus back sequencer
// depends on i2cmts_pkg, i2cmts_stream_if, i2cmts_front and i2cmts_back
//
// Byte-level I2C master sequencer. Each item is either a transaction request (write, read
// or write then repeated-start read) or a completion event from the byte engine; every item
// gives exactly one result carrying the next bus action. Items enter a QUEUE_DEPTH-entry
// queue after classification and are decided one per cycle by the back-end state machine
// while the result channel is not stalled, so the block then sustains one item per clock.
// An accepted item is written into the queue and, when popped from its head, loaded into
// the output result register, from which the result is presented. Stalls on the result
// channel fill the queue, and items keep being taken until it is full.
module i2c_master_transaction_sequencer #(
	parameter int unsigned MAX_BYTES   = 255,
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	i2cmts_stream_if.sink   items,
	i2cmts_stream_if.source results
);
	import i2cmts_pkg::*;

	logic head_valid;
	cmd_t head;
	logic pop;

	// classify and queue
	i2cmts_front #(
		.MAX_BYTES   (MAX_BYTES),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (items),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	// sequence bus actions
	i2cmts_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.results    (results)
	);
endmodule
